[rtl/uvsv_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvsv_pkg
// Shared constants and helpers for the UV sphere vertex generator.
// ----------------------------------------------------------------------------
package uvsv_pkg;

    localparam int MAX_SEGMENTS_DEF = 64;

    // configuration register indexes
    localparam logic [1:0] REG_SEGMENTS = 2'd0;
    localparam logic [1:0] REG_RADIUS   = 2'd1;

    localparam logic [6:0]  SEGMENTS_RST = 7'd18;
    localparam logic [15:0] RADIUS_RST   = 16'd256;

    // pi/2 in Q30 and 1.0 in Q30
    localparam logic [30:0] PI_HALF_Q30 = 31'd1686629713;
    localparam logic [30:0] Q30_ONE     = 31'h4000_0000;

    // Taylor series divisors, Horner order
    localparam int COS_STEPS = 5;
    localparam int SIN_STEPS = 4;
    localparam int unsigned COS_DIV [COS_STEPS] = '{90, 56, 30, 12, 2};
    localparam int unsigned SIN_DIV [SIN_STEPS] = '{72, 42, 20, 6};

    // x^2 stage plus three stages per Horner step
    localparam int POLY_LAT = 1 + 3 * COS_STEPS;

    // quotient bits resolved per divider stage
    localparam int DIV_STEP_BITS = 4;

    // quadrant codes
    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    // signed right shift, round to nearest, ties away from zero
    function automatic logic signed [63:0] rnd_shift(logic signed [63:0] v, int unsigned sh);
        logic [63:0] mag;
        logic [63:0] half;
        logic        neg;
        neg  = v[63];
        mag  = neg ? 64'(-v) : 64'(v);
        half = 64'd1 << (sh - 1);
        mag  = (mag + half) >> sh;
        return neg ? -$signed(mag) : $signed(mag);
    endfunction

endpackage

[rtl/uv_sphere_vertex_generator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uv_sphere_vertex_generator
// Normal, position, texture coordinates and strip indices of one UV sphere
// grid point.
// Throughput: one grid point per cycle, busy never rises; the receiver
// cannot stall, so results leave on done without any hold-off.
// Pipeline: capture, range check, divider operands, the dividers, the Taylor
// pipes and stages A to D; done rises with the registered results.
// Reset: segments = 18, radius = 1.0, pipeline emptied.
// ----------------------------------------------------------------------------
module uv_sphere_vertex_generator #(
    parameter int MAX_SEGMENTS = uvsv_pkg::MAX_SEGMENTS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [6:0]         row,
    input  logic [7:0]         column,
    input  logic               cfg_wen,
    input  logic [1:0]         cfg_addr,
    input  logic [15:0]        cfg_wdata,
    output logic               done,
    output logic signed [16:0] pos_x,
    output logic signed [16:0] pos_y,
    output logic signed [16:0] pos_z,
    output logic signed [15:0] norm_x,
    output logic signed [15:0] norm_y,
    output logic signed [15:0] norm_z,
    output logic [15:0]        tex_u,
    output logic [15:0]        tex_v,
    output logic [13:0]        strip_upper,
    output logic [13:0]        strip_lower,
    output logic               strip_valid,
    output logic               bad_coord
);

    localparam int N_W      = $clog2(MAX_SEGMENTS + 1);
    localparam int D_W      = N_W + 1;
    localparam int T_W      = N_W + 2;
    localparam int NUM_W    = 31 + N_W;
    localparam int DIV_LAT  = (NUM_W + uvsv_pkg::DIV_STEP_BITS - 1) / uvsv_pkg::DIV_STEP_BITS;
    localparam int SIDE_LEN = DIV_LAT + uvsv_pkg::POLY_LAT;
    localparam int TEX_LEN  = uvsv_pkg::POLY_LAT;

    typedef struct packed {
        logic [1:0]     q;
        logic           flip;
        logic [N_W-1:0] rr;
    } ang_t;

    typedef struct packed {
        logic        valid;
        logic        bad;
        logic        strip_ok;
        logic [13:0] upper;
        logic [13:0] lower;
        logic [1:0]  q_i;
        logic        flip_i;
        logic [1:0]  q_j;
        logic        flip_j;
    } side_t;

    typedef struct packed {
        logic [15:0] u;
        logic [15:0] v;
    } tex_t;

    typedef struct packed {
        logic signed [31:0] s;
        logic signed [31:0] c;
    } sc_t;

    // exact reduction of 2k against n: quadrant, residual, octant fold
    function automatic ang_t reduce(logic [T_W-1:0] t, logic [N_W-1:0] n);
        logic [T_W-1:0] nn;
        logic [T_W-1:0] r;
        ang_t           a;
        nn = T_W'(n);
        if (t >= nn + (nn << 1))
        begin
            a.q = uvsv_pkg::QUAD_3;
            r   = t - nn - (nn << 1);
        end
        else if (t >= (nn << 1))
        begin
            a.q = uvsv_pkg::QUAD_2;
            r   = t - (nn << 1);
        end
        else if (t >= nn)
        begin
            a.q = uvsv_pkg::QUAD_1;
            r   = t - nn;
        end
        else
        begin
            a.q = uvsv_pkg::QUAD_0;
            r   = t;
        end
        a.flip = {r, 1'b0} > {1'b0, nn};
        a.rr   = a.flip ? N_W'(nn - r) : N_W'(r);
        return a;
    endfunction

    function automatic sc_t place(logic [1:0] q, logic flip, logic [29:0] s, logic [30:0] c);
        logic signed [31:0] a;
        logic signed [31:0] b;
        sc_t                o;
        a = flip ? $signed({1'b0, c}) : $signed({2'b0, s});
        b = flip ? $signed({2'b0, s}) : $signed({1'b0, c});
        case (q)
            uvsv_pkg::QUAD_0: begin o.s = a;  o.c = b;  end
            uvsv_pkg::QUAD_1: begin o.s = b;  o.c = -a; end
            uvsv_pkg::QUAD_2: begin o.s = -a; o.c = -b; end
            default:          begin o.s = -b; o.c = a;  end
        endcase
        return o;
    endfunction

    // ---------------- configuration ----------------
    logic [6:0]     segments_reg;
    logic [15:0]    radius_reg;
    logic [N_W-1:0] n_reg;
    logic [N_W-1:0] n_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            segments_reg <= uvsv_pkg::SEGMENTS_RST;
            radius_reg   <= uvsv_pkg::RADIUS_RST;
        end
        else if (cfg_wen)
        begin
            case (cfg_addr)
                uvsv_pkg::REG_SEGMENTS: segments_reg <= cfg_wdata[6:0];
                uvsv_pkg::REG_RADIUS:   radius_reg   <= cfg_wdata;
                default:                ;
            endcase
        end
    end

    always_comb
    begin
        if (segments_reg == 7'd0)
            n_next = N_W'(1);
        else if (32'(segments_reg) > MAX_SEGMENTS)
            n_next = N_W'(MAX_SEGMENTS);
        else
            n_next = N_W'(segments_reg);
    end

    always_ff @(posedge clk)
    begin
        n_reg <= n_next;
    end

    assign busy = 1'b0;

    // ---------------- stage 1: capture ----------------
    logic       s1_valid_reg;
    logic [6:0] s1_row_reg;
    logic [7:0] s1_col_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= start & ~busy;
    end

    always_ff @(posedge clk)
    begin
        s1_row_reg <= row;
        s1_col_reg <= column;
    end

    // ---------------- stage 2: range check, angle reduction ----------------
    logic             s2_valid_reg;
    logic             s2_bad_reg;
    logic             s2_strip_ok_reg;
    logic [13:0]      s2_upper_reg;
    logic [13:0]      s2_lower_reg;
    ang_t             s2_ai_reg;
    ang_t             s2_aj_reg;
    logic [NUM_W-1:0] s2_num_u_reg;
    logic [NUM_W-1:0] s2_num_v_reg;

    logic [D_W-1:0]   n2;
    logic [7:0]       km_j;
    logic [15:0]      width16;
    logic [15:0]      upper16;
    logic             strip_ok;

    assign n2       = {n_reg, 1'b0};
    assign km_j     = (32'(s1_col_reg) == 32'(n2)) ? 8'd0 : s1_col_reg;
    assign width16  = 16'(n2) + 16'd1;
    assign upper16  = 16'(s1_row_reg) * width16 + 16'(s1_col_reg);
    assign strip_ok = 32'(s1_row_reg) < 32'(n_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        s2_bad_reg      <= (32'(s1_row_reg) > 32'(n_reg)) || (32'(s1_col_reg) > 32'(n2));
        s2_strip_ok_reg <= strip_ok;
        s2_upper_reg    <= strip_ok ? upper16[13:0] : 14'd0;
        s2_lower_reg    <= strip_ok ? 14'(upper16 + width16) : 14'd0;
        s2_ai_reg       <= reduce(T_W'({s1_row_reg, 1'b0}), n_reg);
        s2_aj_reg       <= reduce(T_W'({km_j, 1'b0}), n_reg);
        s2_num_u_reg    <= (NUM_W'(s1_col_reg) << 15) + NUM_W'(n_reg);
        s2_num_v_reg    <= ((NUM_W'(n_reg) - NUM_W'(s1_row_reg)) << 15) + NUM_W'(n_reg >> 1);
    end

    // ---------------- stage 3: divider operands ----------------
    side_t            s3_side_reg;
    logic [NUM_W-1:0] s3_num_i_reg;
    logic [NUM_W-1:0] s3_num_j_reg;
    logic [NUM_W-1:0] s3_num_u_reg;
    logic [NUM_W-1:0] s3_num_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_side_reg <= '0;
        else
        begin
            s3_side_reg.valid    <= s2_valid_reg;
            s3_side_reg.bad      <= s2_bad_reg;
            s3_side_reg.strip_ok <= s2_strip_ok_reg;
            s3_side_reg.upper    <= s2_upper_reg;
            s3_side_reg.lower    <= s2_lower_reg;
            s3_side_reg.q_i      <= s2_ai_reg.q;
            s3_side_reg.flip_i   <= s2_ai_reg.flip;
            s3_side_reg.q_j      <= s2_aj_reg.q;
            s3_side_reg.flip_j   <= s2_aj_reg.flip;
        end
    end

    always_ff @(posedge clk)
    begin
        s3_num_i_reg <= NUM_W'(uvsv_pkg::PI_HALF_Q30) * NUM_W'(s2_ai_reg.rr)
                        + NUM_W'(n_reg >> 1);
        s3_num_j_reg <= NUM_W'(uvsv_pkg::PI_HALF_Q30) * NUM_W'(s2_aj_reg.rr)
                        + NUM_W'(n_reg >> 1);
        s3_num_u_reg <= s2_num_u_reg;
        s3_num_v_reg <= s2_num_v_reg;
    end

    // ---------------- dividers ----------------
    logic [NUM_W-1:0] quo_i;
    logic [NUM_W-1:0] quo_j;
    logic [NUM_W-1:0] quo_u;
    logic [NUM_W-1:0] quo_v;

    uvsv_div #(.NUM_W(NUM_W), .DEN_W(D_W)) u_div_i (
        .clk (clk),
        .num (s3_num_i_reg),
        .den (D_W'(n_reg)),
        .quo (quo_i)
    );

    uvsv_div #(.NUM_W(NUM_W), .DEN_W(D_W)) u_div_j (
        .clk (clk),
        .num (s3_num_j_reg),
        .den (D_W'(n_reg)),
        .quo (quo_j)
    );

    uvsv_div #(.NUM_W(NUM_W), .DEN_W(D_W)) u_div_u (
        .clk (clk),
        .num (s3_num_u_reg),
        .den (n2),
        .quo (quo_u)
    );

    uvsv_div #(.NUM_W(NUM_W), .DEN_W(D_W)) u_div_v (
        .clk (clk),
        .num (s3_num_v_reg),
        .den (D_W'(n_reg)),
        .quo (quo_v)
    );

    // ---------------- sine / cosine ----------------
    logic [29:0] sin_i;
    logic [30:0] cos_i;
    logic [29:0] sin_j;
    logic [30:0] cos_j;

    uvsv_poly u_poly_i (
        .clk   (clk),
        .x     (quo_i[29:0]),
        .sin_q (sin_i),
        .cos_q (cos_i)
    );

    uvsv_poly u_poly_j (
        .clk   (clk),
        .x     (quo_j[29:0]),
        .sin_q (sin_j),
        .cos_q (cos_j)
    );

    // ---------------- sideband delay lines ----------------
    side_t side_pipe_reg [SIDE_LEN];
    tex_t  tex_pipe_reg  [TEX_LEN];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < SIDE_LEN; k++)
                side_pipe_reg[k] <= '0;
        end
        else
        begin
            side_pipe_reg[0] <= s3_side_reg;
            for (int k = 1; k < SIDE_LEN; k++)
                side_pipe_reg[k] <= side_pipe_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        tex_pipe_reg[0] <= '{u: quo_u[15:0], v: quo_v[15:0]};
        for (int k = 1; k < TEX_LEN; k++)
            tex_pipe_reg[k] <= tex_pipe_reg[k-1];
    end

    // ---------------- stage A: quadrant signs ----------------
    side_t a_side_reg;
    tex_t  a_tex_reg;
    sc_t   a_i_reg;
    sc_t   a_j_reg;
    side_t side_end;

    assign side_end = side_pipe_reg[SIDE_LEN-1];

    // ---------------- stage B: normal products ----------------
    side_t              b_side_reg;
    tex_t               b_tex_reg;
    logic signed [61:0] b_px_reg;
    logic signed [61:0] b_py_reg;
    logic signed [31:0] b_nz_reg;

    // ---------------- stage C: normals in Q30 ----------------
    side_t              c_side_reg;
    tex_t               c_tex_reg;
    logic signed [31:0] c_nx_reg;
    logic signed [31:0] c_ny_reg;
    logic signed [31:0] c_nz_reg;

    // ---------------- stage D: radius scale ----------------
    side_t              d_side_reg;
    tex_t               d_tex_reg;
    logic signed [48:0] d_px_reg;
    logic signed [48:0] d_py_reg;
    logic signed [48:0] d_pz_reg;
    logic signed [15:0] d_nx_reg;
    logic signed [15:0] d_ny_reg;
    logic signed [15:0] d_nz_reg;
    logic signed [48:0] rad_s;

    assign rad_s = 49'($signed({1'b0, radius_reg}));

    logic valid_a_reg, valid_b_reg, valid_c_reg, valid_d_reg, done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
            valid_c_reg <= 1'b0;
            valid_d_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            valid_a_reg <= side_end.valid;
            valid_b_reg <= valid_a_reg;
            valid_c_reg <= valid_b_reg;
            valid_d_reg <= valid_c_reg;
            done_reg    <= valid_d_reg;
        end
    end

    logic signed [16:0] pos_x_reg, pos_y_reg, pos_z_reg;
    logic signed [15:0] norm_x_reg, norm_y_reg, norm_z_reg;
    logic [15:0]        tex_u_reg, tex_v_reg;
    logic [13:0]        upper_reg, lower_reg;
    logic               strip_valid_reg, bad_reg;

    always_ff @(posedge clk)
    begin
        a_side_reg <= side_end;
        a_tex_reg  <= tex_pipe_reg[TEX_LEN-1];
        a_i_reg    <= place(side_end.q_i, side_end.flip_i, sin_i, cos_i);
        a_j_reg    <= place(side_end.q_j, side_end.flip_j, sin_j, cos_j);

        b_side_reg <= a_side_reg;
        b_tex_reg  <= a_tex_reg;
        b_px_reg   <= 62'(a_i_reg.s) * 62'(a_j_reg.c);
        b_py_reg   <= 62'(a_i_reg.s) * 62'(a_j_reg.s);
        b_nz_reg   <= a_i_reg.c;

        c_side_reg <= b_side_reg;
        c_tex_reg  <= b_tex_reg;
        c_nx_reg   <= 32'(uvsv_pkg::rnd_shift(64'(b_px_reg), 30));
        c_ny_reg   <= 32'(uvsv_pkg::rnd_shift(64'(b_py_reg), 30));
        c_nz_reg   <= b_nz_reg;

        d_side_reg <= c_side_reg;
        d_tex_reg  <= c_tex_reg;
        d_px_reg   <= 49'(c_nx_reg) * rad_s;
        d_py_reg   <= 49'(c_ny_reg) * rad_s;
        d_pz_reg   <= 49'(c_nz_reg) * rad_s;
        d_nx_reg   <= 16'(uvsv_pkg::rnd_shift(64'(c_nx_reg), 16));
        d_ny_reg   <= 16'(uvsv_pkg::rnd_shift(64'(c_ny_reg), 16));
        d_nz_reg   <= 16'(uvsv_pkg::rnd_shift(64'(c_nz_reg), 16));

        // out-of-range points report only the flag
        if (d_side_reg.bad)
        begin
            pos_x_reg       <= '0;
            pos_y_reg       <= '0;
            pos_z_reg       <= '0;
            norm_x_reg      <= '0;
            norm_y_reg      <= '0;
            norm_z_reg      <= '0;
            tex_u_reg       <= '0;
            tex_v_reg       <= '0;
            upper_reg       <= '0;
            lower_reg       <= '0;
            strip_valid_reg <= 1'b0;
        end
        else
        begin
            pos_x_reg       <= 17'(uvsv_pkg::rnd_shift(64'(d_px_reg), 30));
            pos_y_reg       <= 17'(uvsv_pkg::rnd_shift(64'(d_py_reg), 30));
            pos_z_reg       <= 17'(uvsv_pkg::rnd_shift(64'(d_pz_reg), 30));
            norm_x_reg      <= d_nx_reg;
            norm_y_reg      <= d_ny_reg;
            norm_z_reg      <= d_nz_reg;
            tex_u_reg       <= d_tex_reg.u;
            tex_v_reg       <= d_tex_reg.v;
            upper_reg       <= d_side_reg.upper;
            lower_reg       <= d_side_reg.lower;
            strip_valid_reg <= d_side_reg.strip_ok;
        end
        bad_reg <= d_side_reg.bad;
    end

    assign done        = done_reg;
    assign pos_x       = pos_x_reg;
    assign pos_y       = pos_y_reg;
    assign pos_z       = pos_z_reg;
    assign norm_x      = norm_x_reg;
    assign norm_y      = norm_y_reg;
    assign norm_z      = norm_z_reg;
    assign tex_u       = tex_u_reg;
    assign tex_v       = tex_v_reg;
    assign strip_upper = upper_reg;
    assign strip_lower = lower_reg;
    assign strip_valid = strip_valid_reg;
    assign bad_coord   = bad_reg;

endmodule

[rtl/uvsv_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvsv_div
// Pipelined restoring divider, STEP_BITS quotient bits per stage; the user
// must hold the divisor steady while items flow; the block does not check.
// ----------------------------------------------------------------------------
module uvsv_div #(
    parameter int NUM_W     = 38,
    parameter int DEN_W     = 8,
    parameter int STEP_BITS = uvsv_pkg::DIV_STEP_BITS
) (
    input  logic             clk,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [NUM_W-1:0] quo
);

    localparam int STEPS = (NUM_W + STEP_BITS - 1) / STEP_BITS;
    localparam int PAD_W = STEPS * STEP_BITS;

    logic [PAD_W-1:0] work_v [STEPS+1];
    logic [DEN_W-1:0] rem_v  [STEPS+1];

    assign work_v[0] = PAD_W'(num);
    assign rem_v[0]  = '0;

    for (genvar s = 0; s < STEPS; s++) begin : g_stage
        logic [PAD_W-1:0] work_reg;
        logic [PAD_W-1:0] work_next;
        logic [DEN_W-1:0] rem_reg;
        logic [DEN_W-1:0] rem_next;

        always_comb
        begin
            logic [PAD_W-1:0] w;
            logic [DEN_W:0]   r;
            w = work_v[s];
            r = {1'b0, rem_v[s]};
            for (int b = 0; b < STEP_BITS; b++)
            begin
                r = {r[DEN_W-1:0], w[PAD_W-1]};
                w = {w[PAD_W-2:0], 1'b0};
                if (r >= {1'b0, den})
                begin
                    r    = r - {1'b0, den};
                    w[0] = 1'b1;
                end
            end
            work_next = w;
            rem_next  = r[DEN_W-1:0];
        end

        always_ff @(posedge clk)
        begin
            work_reg <= work_next;
            rem_reg  <= rem_next;
        end

        assign work_v[s+1] = work_reg;
        assign rem_v[s+1]  = rem_reg;
    end

    assign quo = work_v[STEPS][NUM_W-1:0];

endmodule

[rtl/uvsv_poly.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvsv_poly
// Sine and cosine of a first-octant angle in Q30 by truncated Taylor
// series, Horner form, three stages per step, both chains side by side.
// ----------------------------------------------------------------------------
module uvsv_poly (
    input  logic        clk,
    input  logic [29:0] x,
    output logic [29:0] sin_q,
    output logic [30:0] cos_q
);

    localparam int STEPS = uvsv_pkg::COS_STEPS;

    logic [29:0] x2_reg;
    logic [29:0] x0_reg;
    logic [59:0] sq;

    logic [29:0] x2_v [STEPS+1];
    logic [29:0] x_v  [STEPS+1];
    logic [30:0] tc_v [STEPS+1];
    logic [30:0] ts_v [STEPS+1];

    assign sq = 60'(x) * 60'(x);

    always_ff @(posedge clk)
    begin
        x2_reg <= sq[59:30];
        x0_reg <= x;
    end

    assign x2_v[0] = x2_reg;
    assign x_v[0]  = x0_reg;
    assign tc_v[0] = uvsv_pkg::Q30_ONE;
    assign ts_v[0] = uvsv_pkg::Q30_ONE;

    for (genvar k = 0; k < STEPS; k++) begin : g_step
        localparam logic [31:0] MC = 32'((64'd1 << 32) / 64'(uvsv_pkg::COS_DIV[k]));

        logic [29:0] x2_a_reg, x2_b_reg, x2_c_reg;
        logic [29:0] x_a_reg, x_b_reg, x_c_reg;
        logic [29:0] pc_a_reg, pc_b_reg, qc_b_reg;
        logic [30:0] tc_reg;
        logic [60:0] pc_prod;
        logic [61:0] qc_prod;
        logic [29:0] qc;

        assign pc_prod = 61'(x2_v[k]) * 61'(tc_v[k]);
        assign qc_prod = 62'(pc_a_reg) * 62'(MC);
        // reciprocal estimate is at most one low
        assign qc = ((32'(qc_b_reg) + 32'd1) * 32'(uvsv_pkg::COS_DIV[k]) <= 32'(pc_b_reg))
                    ? qc_b_reg + 30'd1 : qc_b_reg;

        always_ff @(posedge clk)
        begin
            pc_a_reg <= pc_prod[59:30];
            x2_a_reg <= x2_v[k];
            x_a_reg  <= x_v[k];
            pc_b_reg <= pc_a_reg;
            qc_b_reg <= qc_prod[61:32];
            x2_b_reg <= x2_a_reg;
            x_b_reg  <= x_a_reg;
            tc_reg   <= uvsv_pkg::Q30_ONE - 31'(qc);
            x2_c_reg <= x2_b_reg;
            x_c_reg  <= x_b_reg;
        end

        assign tc_v[k+1] = tc_reg;
        assign x2_v[k+1] = x2_c_reg;
        assign x_v[k+1]  = x_c_reg;

        if (k < uvsv_pkg::SIN_STEPS) begin : g_sin
            localparam logic [31:0] MS = 32'((64'd1 << 32) / 64'(uvsv_pkg::SIN_DIV[k]));

            logic [29:0] ps_a_reg, ps_b_reg, qs_b_reg;
            logic [30:0] ts_reg;
            logic [60:0] ps_prod;
            logic [61:0] qs_prod;
            logic [29:0] qs;

            assign ps_prod = 61'(x2_v[k]) * 61'(ts_v[k]);
            assign qs_prod = 62'(ps_a_reg) * 62'(MS);
            assign qs = ((32'(qs_b_reg) + 32'd1) * 32'(uvsv_pkg::SIN_DIV[k]) <= 32'(ps_b_reg))
                        ? qs_b_reg + 30'd1 : qs_b_reg;

            always_ff @(posedge clk)
            begin
                ps_a_reg <= ps_prod[59:30];
                ps_b_reg <= ps_a_reg;
                qs_b_reg <= qs_prod[61:32];
                ts_reg   <= uvsv_pkg::Q30_ONE - 31'(qs);
            end

            assign ts_v[k+1] = ts_reg;
        end else begin : g_fin
            // last sine step: x * t, then held to line up with cosine
            logic [29:0] s_a_reg, s_b_reg, s_c_reg;
            logic [60:0] s_prod;

            assign s_prod = 61'(x_v[k]) * 61'(ts_v[k]);

            always_ff @(posedge clk)
            begin
                s_a_reg <= s_prod[59:30];
                s_b_reg <= s_a_reg;
                s_c_reg <= s_b_reg;
            end

            assign ts_v[k+1] = 31'(s_c_reg);
        end
    end

    assign sin_q = ts_v[STEPS][29:0];
    assign cos_q = tc_v[STEPS];

endmodule
